>>> rtl/x86dec_pkg.sv
// Package for the scalar x86-64 instruction decoder.
// Holds the status and operation codes, opcode constants and the decode phase type.
// It depends on nothing and is imported by x86_scalar_instruction_decoder_core.
package x86dec_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_MOVE = 4'd1;
    localparam logic [3:0] OP_ADD  = 4'd2;
    localparam logic [3:0] OP_SUB  = 4'd3;
    localparam logic [3:0] OP_CMP  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_XOR  = 4'd6;
    localparam logic [3:0] OP_OR   = 4'd7;
    localparam logic [3:0] OP_TEST = 4'd8;

    localparam logic [7:0] OPC_REX_LO  = 8'h40;
    localparam logic [7:0] OPC_REX_HI  = 8'h4f;
    localparam logic [7:0] OPC_NOP     = 8'h90;
    localparam logic [7:0] OPC_MOVI_LO = 8'hb8;
    localparam logic [7:0] OPC_MOVI_HI = 8'hbf;
    localparam logic [7:0] OPC_GRP_I32 = 8'h81;
    localparam logic [7:0] OPC_GRP_I8  = 8'h83;
    localparam logic [7:0] OPC_TEST    = 8'h85;
    localparam logic [7:0] OPC_MOV_ST  = 8'h89;
    localparam logic [7:0] OPC_MOV_LD  = 8'h8b;
    localparam logic [7:0] OPC_ADD_ST  = 8'h01;
    localparam logic [7:0] OPC_ADD_LD  = 8'h03;
    localparam logic [7:0] OPC_OR_ST   = 8'h09;
    localparam logic [7:0] OPC_OR_LD   = 8'h0b;
    localparam logic [7:0] OPC_AND_ST  = 8'h21;
    localparam logic [7:0] OPC_AND_LD  = 8'h23;
    localparam logic [7:0] OPC_SUB_ST  = 8'h29;
    localparam logic [7:0] OPC_SUB_LD  = 8'h2b;
    localparam logic [7:0] OPC_XOR_ST  = 8'h31;
    localparam logic [7:0] OPC_XOR_LD  = 8'h33;
    localparam logic [7:0] OPC_CMP_ST  = 8'h39;
    localparam logic [7:0] OPC_CMP_LD  = 8'h3b;

    // Group /digit codes for 0x81 and 0x83.
    localparam logic [2:0] DIG_ADD = 3'd0;
    localparam logic [2:0] DIG_OR  = 3'd1;
    localparam logic [2:0] DIG_AND = 3'd4;
    localparam logic [2:0] DIG_SUB = 3'd5;
    localparam logic [2:0] DIG_XOR = 3'd6;
    localparam logic [2:0] DIG_CMP = 3'd7;

    localparam logic [1:0]  MOD_REG       = 2'b11;
    localparam logic [3:0]  MAX_COUNT     = 4'd15;
    localparam logic [3:0]  IMM32_BYTES   = 4'd4;
    localparam logic [3:0]  IMM64_BYTES   = 4'd8;
    localparam logic [3:0]  IMM8_BYTES    = 4'd1;
    localparam logic [63:0] CANON_LOW_MAX = 64'h0000_7fff_ffff_ffff;
    localparam logic [63:0] CANON_HI_MIN  = 64'hffff_8000_0000_0000;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_FIRST  = 5'b00010,
        PH_OPCODE = 5'b00100,
        PH_MODRM  = 5'b01000,
        PH_IMM    = 5'b10000
    } phase_t;

    function automatic logic is_canonical(input logic [63:0] a);
        return (a <= CANON_LOW_MAX) || (a >= CANON_HI_MIN);
    endfunction

endpackage

>>> rtl/x86_scalar_instruction_decoder_core.sv
// Byte-serial decoder for a small subset of x86-64 scalar integer instructions.
// Per-byte decode state and one output record register; uses x86dec_pkg.
//
// Usage: code bytes arrive on the code channel (code_valid / code_stall), one
// request per byte. start_new marks the first byte of a buffer and samples
// start_address; buffer_end marks the last byte available. Each instruction,
// and each error found while decoding it, yields exactly one request on the
// record channel (record_valid / record_stall). Bytes that arrive after a
// record and before the next start_new are consumed and ignored.
// Throughput is one byte per cycle unless a held record stalls. A record is
// presented in the cycle after the byte that completes or fails the instruction
// is taken; this is set by the single output register behind the decode logic.
// A held record blocks the code channel only if the receiver stalls it; while
// record_stall is low, bytes flow every cycle.
// Reset (rst_n low, asynchronous) returns the decoder to idle, waiting for a
// byte with start_new set, and drops any record not yet taken.
module x86_scalar_instruction_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        code_valid,
    output logic        code_stall,
    input  logic [7:0]  code_byte,
    input  logic        start_new,
    input  logic        buffer_end,
    input  logic [63:0] start_address,
    output logic        record_valid,
    input  logic        record_stall,
    output logic [1:0]  status,
    output logic [3:0]  operation,
    output logic        wide,
    output logic [3:0]  destination,
    output logic [3:0]  source,
    output logic        has_immediate,
    output logic [63:0] immediate_value,
    output logic [3:0]  length,
    output logic [63:0] decoded_address
);
    import x86dec_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  rex_reg, rex_next;
    logic        rex_seen_reg, rex_seen_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [63:0] imm_reg, imm_next;
    logic [3:0]  need_reg, need_next;
    logic [2:0]  idx_reg, idx_next;
    logic [3:0]  count_reg, count_next;
    logic [63:0] addr_reg, addr_next;
    logic [3:0]  pop_reg, pop_next;
    logic [3:0]  pdst_reg, pdst_next;
    logic [3:0]  psrc_reg, psrc_next;
    logic        pimm_reg, pimm_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg;
    logic [3:0]  operation_reg;
    logic        wide_reg;
    logic [3:0]  destination_reg;
    logic [3:0]  source_reg;
    logic        has_imm_reg;
    logic [63:0] imm_out_reg;
    logic [3:0]  length_reg;
    logic [63:0] addr_out_reg;

    logic        take;
    logic        do_opcode;
    logic        finish;
    logic        fail;
    logic [1:0]  fail_status;
    logic        emit;
    logic [1:0]  rec_status;
    logic        rec_ok;
    logic        is_group;
    logic [2:0]  digit;
    logic [3:0]  reg_field;
    logic [3:0]  rm_field;
    logic [64:0] end_sum;

    assign code_stall = out_valid_reg && record_stall;
    assign take       = code_valid && !code_stall;

    always_comb
    begin
        // A start marker clears the decode state before the byte is looked at.
        phase_next    = start_new ? PH_FIRST : phase_reg;
        rex_next      = start_new ? 4'd0 : rex_reg;
        rex_seen_next = start_new ? 1'b0 : rex_seen_reg;
        opcode_next   = start_new ? 8'd0 : opcode_reg;
        imm_next      = start_new ? 64'd0 : imm_reg;
        need_next     = start_new ? 4'd0 : need_reg;
        idx_next      = start_new ? 3'd0 : idx_reg;
        count_next    = start_new ? 4'd0 : count_reg;
        addr_next     = start_new ? start_address : addr_reg;
        pop_next      = start_new ? OP_NOP : pop_reg;
        pdst_next     = start_new ? 4'd0 : pdst_reg;
        psrc_next     = start_new ? 4'd0 : psrc_reg;
        pimm_next     = start_new ? 1'b0 : pimm_reg;

        do_opcode   = 1'b0;
        finish      = 1'b0;
        fail        = 1'b0;
        fail_status = ST_UNSUP;
        is_group    = (opcode_next == OPC_GRP_I32) || (opcode_next == OPC_GRP_I8);
        digit       = code_byte[5:3];
        reg_field   = {rex_next[2], code_byte[5:3]};
        rm_field    = {rex_next[0], code_byte[2:0]};

        if (phase_next != PH_IDLE && count_next < MAX_COUNT)
        begin
            count_next = count_next + 4'd1;
        end

        unique case (phase_next)
            PH_IDLE:
            begin
            end
            PH_FIRST:
            begin
                if (code_byte >= OPC_REX_LO && code_byte <= OPC_REX_HI)
                begin
                    rex_seen_next = 1'b1;
                    rex_next      = code_byte[3:0];
                    phase_next    = PH_OPCODE;
                end
                else
                begin
                    do_opcode = 1'b1;
                end
            end
            PH_OPCODE:
            begin
                do_opcode = 1'b1;
            end
            PH_MODRM:
            begin
                if (code_byte[7:6] != MOD_REG)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    pdst_next = (!is_group && opcode_next[1]) ? reg_field : rm_field;
                    psrc_next = opcode_next[1] ? rm_field : reg_field;
                    if (!is_group)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        unique case (digit)
                            DIG_ADD: pop_next = OP_ADD;
                            DIG_OR:  pop_next = OP_OR;
                            DIG_AND: pop_next = OP_AND;
                            DIG_SUB: pop_next = OP_SUB;
                            DIG_XOR: pop_next = OP_XOR;
                            DIG_CMP: pop_next = OP_CMP;
                            default: fail = 1'b1;
                        endcase
                        pimm_next  = 1'b1;
                        need_next  = (opcode_next == OPC_GRP_I8) ? IMM8_BYTES : IMM32_BYTES;
                        idx_next   = 3'd0;
                        phase_next = PH_IMM;
                    end
                end
            end
            PH_IMM:
            begin
                imm_next = imm_next | (64'(code_byte) << {idx_next, 3'b000});
                idx_next = idx_next + 3'd1;
                if (need_next != 4'd0)
                begin
                    need_next = need_next - 4'd1;
                end
                if (need_next == 4'd0)
                begin
                    finish = 1'b1;
                    if (opcode_next == OPC_GRP_I8)
                    begin
                        imm_next = {{56{imm_next[7]}}, imm_next[7:0]};
                    end
                    else if (opcode_next == OPC_GRP_I32)
                    begin
                        imm_next = {{32{imm_next[31]}}, imm_next[31:0]};
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (do_opcode)
        begin
            opcode_next = code_byte;
            phase_next  = PH_MODRM;
            if (code_byte == OPC_NOP && !rex_seen_next)
            begin
                pop_next = OP_NOP;
                finish   = 1'b1;
            end
            else
            begin
                unique case (code_byte) inside
                    [OPC_MOVI_LO:OPC_MOVI_HI]:
                    begin
                        pop_next   = OP_MOVE;
                        pimm_next  = 1'b1;
                        pdst_next  = {rex_next[0], code_byte[2:0]};
                        need_next  = rex_next[3] ? IMM64_BYTES : IMM32_BYTES;
                        idx_next   = 3'd0;
                        phase_next = PH_IMM;
                    end
                    OPC_MOV_ST, OPC_MOV_LD: pop_next = OP_MOVE;
                    OPC_ADD_ST, OPC_ADD_LD: pop_next = OP_ADD;
                    OPC_OR_ST,  OPC_OR_LD:  pop_next = OP_OR;
                    OPC_AND_ST, OPC_AND_LD: pop_next = OP_AND;
                    OPC_SUB_ST, OPC_SUB_LD: pop_next = OP_SUB;
                    OPC_XOR_ST, OPC_XOR_LD: pop_next = OP_XOR;
                    OPC_CMP_ST, OPC_CMP_LD: pop_next = OP_CMP;
                    OPC_TEST:               pop_next = OP_TEST;
                    OPC_GRP_I32, OPC_GRP_I8:
                    begin
                    end
                    default: fail = 1'b1;
                endcase
            end
        end

        end_sum = {1'b0, addr_next} + {61'd0, count_next};
        rec_ok  = !end_sum[64] && is_canonical(addr_next) && is_canonical(end_sum[63:0]);

        if (fail)
        begin
            rec_status = ST_UNSUP;
        end
        else if (finish)
        begin
            rec_status = rec_ok ? ST_OK : ST_INVALID;
        end
        else
        begin
            rec_status = ST_TRUNC;
        end
        fail_status = rec_status;

        // Truncation only applies when the byte neither completed nor failed.
        emit = (phase_next != PH_IDLE || fail || finish)
               && (fail || finish || buffer_end);
        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && record_stall;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rex_reg       <= 4'd0;
            rex_seen_reg  <= 1'b0;
            opcode_reg    <= 8'd0;
            imm_reg       <= 64'd0;
            need_reg      <= 4'd0;
            idx_reg       <= 3'd0;
            count_reg     <= 4'd0;
            addr_reg      <= 64'd0;
            pop_reg       <= OP_NOP;
            pdst_reg      <= 4'd0;
            psrc_reg      <= 4'd0;
            pimm_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg    <= phase_next;
                rex_reg      <= rex_next;
                rex_seen_reg <= rex_seen_next;
                opcode_reg   <= opcode_next;
                imm_reg      <= imm_next;
                need_reg     <= need_next;
                idx_reg      <= idx_next;
                count_reg    <= count_next;
                addr_reg     <= addr_next;
                pop_reg      <= pop_next;
                pdst_reg     <= pdst_next;
                psrc_reg     <= psrc_next;
                pimm_reg     <= pimm_next;
            end
        end
    end

    // Error records carry only status, width and address.
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            status_reg   <= fail_status;
            wide_reg     <= rex_next[3];
            addr_out_reg <= addr_next;
            if (fail_status == ST_OK)
            begin
                operation_reg   <= pop_next;
                destination_reg <= pdst_next;
                source_reg      <= psrc_next;
                has_imm_reg     <= pimm_next;
                imm_out_reg     <= imm_next;
                length_reg      <= count_next;
            end
            else
            begin
                operation_reg   <= OP_NOP;
                destination_reg <= 4'd0;
                source_reg      <= 4'd0;
                has_imm_reg     <= 1'b0;
                imm_out_reg     <= 64'd0;
                length_reg      <= 4'd0;
            end
        end
    end

    assign record_valid    = out_valid_reg;
    assign status          = status_reg;
    assign operation       = operation_reg;
    assign wide            = wide_reg;
    assign destination     = destination_reg;
    assign source          = source_reg;
    assign has_immediate   = has_imm_reg;
    assign immediate_value = imm_out_reg;
    assign length          = length_reg;
    assign decoded_address = addr_out_reg;

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && status == ST_OK |-> length >= 4'd1 && length <= 4'd10)
        else $error("completed instruction has an impossible length");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && status != ST_OK |->
            operation == OP_NOP && !has_immediate && length == 4'd0
            && immediate_value == 64'd0)
        else $error("error record carries result fields");

    a_imm_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IMM |-> need_reg != 4'd0 && pimm_reg)
        else $error("immediate phase with nothing left to collect");

    a_ok_address: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && status == ST_OK |->
            is_canonical(decoded_address) && decoded_address <= decoded_address + length)
        else $error("valid record with bad address range");

    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |=> record_valid)
        else $error("record lost after decode");

endmodule

>>> test/x86_scalar_instruction_decoder_core_tb.sv
// Self-checking testbench for x86_scalar_instruction_decoder_core.
// A scoreboard class predicts one record per decoded instruction from the accepted code bytes;
// it depends on x86dec_pkg and the decoder RTL only.
module x86_scalar_instruction_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import x86dec_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [7:0]  b;
        logic        sn;
        logic        be;
        logic [63:0] a;
    } code_req_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [3:0]  op;
        logic        wide;
        logic [3:0]  dst;
        logic [3:0]  src;
        logic        has_imm;
        logic [63:0] imm_val;
        logic [3:0]  len;
        logic [63:0] addr;
    } dec_record_t;

    class decoder_scoreboard;
        dec_record_t expected_records[$];
        int mismatches;
        int requests_taken;

        // Decoder state as the predictor sees it.
        phase_t      ph;
        logic [3:0]  rex;
        bit          rex_seen;
        logic [7:0]  opc;
        logic [63:0] imm_acc;
        int unsigned need;
        int unsigned imm_idx;
        logic [3:0]  count;
        logic [63:0] inst_addr;
        logic [3:0]  p_op;
        logic [3:0]  p_dst;
        logic [3:0]  p_src;
        bit          p_imm;

        function new();
            clear_decode();
            inst_addr = '0;
            mismatches = 0;
            requests_taken = 0;
        endfunction

        function void clear_decode();
            ph = PH_IDLE;
            rex = '0;
            rex_seen = 0;
            opc = '0;
            imm_acc = '0;
            need = 0;
            imm_idx = 0;
            count = '0;
            p_op = OP_NOP;
            p_dst = '0;
            p_src = '0;
            p_imm = 0;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void push_record(logic [1:0] st, logic [3:0] op, logic [3:0] dst,
                                  logic [3:0] src, bit imm, logic [63:0] val, logic [3:0] len);
            dec_record_t rec;
            rec.st = st;
            rec.op = op;
            rec.wide = rex[3];
            rec.dst = dst;
            rec.src = src;
            rec.has_imm = imm;
            rec.imm_val = val;
            rec.len = len;
            rec.addr = inst_addr;
            expected_records = {expected_records, rec};
        endfunction

        // Error records keep only status, address and width.
        function bit emit_error(logic [1:0] st);
            push_record(st, OP_NOP, '0, '0, 0, '0, '0);
            ph = PH_IDLE;
            return 1;
        endfunction

        function bit complete();
            logic [64:0] sum;
            logic [63:0] end_a;
            sum = {1'b0, inst_addr} + {61'b0, count};
            end_a = sum[63:0];
            if (sum[64] || (inst_addr > CANON_LOW_MAX && inst_addr < CANON_HI_MIN)
                || (end_a > CANON_LOW_MAX && end_a < CANON_HI_MIN))
                return emit_error(ST_INVALID);
            push_record(ST_OK, p_op, p_dst, p_src, p_imm, imm_acc, count);
            ph = PH_IDLE;
            return 1;
        endfunction

        function bit decode_opcode(logic [7:0] b);
            opc = b;
            if (b == OPC_NOP && !rex_seen)
            begin
                p_op = OP_NOP;
                return complete();
            end
            if (b >= OPC_MOVI_LO && b <= OPC_MOVI_HI)
            begin
                p_op = OP_MOVE;
                p_imm = 1;
                p_dst = {rex[0], b[2:0]};
                need = rex[3] ? IMM64_BYTES : IMM32_BYTES;
                imm_idx = 0;
                ph = PH_IMM;
                return 0;
            end
            case (b)
                OPC_MOV_ST, OPC_MOV_LD: p_op = OP_MOVE;
                OPC_ADD_ST, OPC_ADD_LD: p_op = OP_ADD;
                OPC_OR_ST, OPC_OR_LD:   p_op = OP_OR;
                OPC_AND_ST, OPC_AND_LD: p_op = OP_AND;
                OPC_SUB_ST, OPC_SUB_LD: p_op = OP_SUB;
                OPC_XOR_ST, OPC_XOR_LD: p_op = OP_XOR;
                OPC_CMP_ST, OPC_CMP_LD: p_op = OP_CMP;
                OPC_TEST:               p_op = OP_TEST;
                OPC_GRP_I32, OPC_GRP_I8: ;
                default: return emit_error(ST_UNSUP);
            endcase
            ph = PH_MODRM;
            return 0;
        endfunction

        function bit decode_modrm(logic [7:0] b);
            bit grp;
            logic [2:0] digit;
            logic [3:0] reg_n;
            logic [3:0] rm_n;
            grp = (opc == OPC_GRP_I32) || (opc == OPC_GRP_I8);
            digit = b[5:3];
            reg_n = {rex[2], digit};
            rm_n = {rex[0], b[2:0]};
            if (b[7:6] != MOD_REG)
                return emit_error(ST_UNSUP);
            // Bit 1 of the opcode selects the direction, which also moves the source.
            p_dst = (!grp && opc[1]) ? reg_n : rm_n;
            p_src = opc[1] ? rm_n : reg_n;
            if (!grp)
                return complete();
            case (digit)
                DIG_ADD: p_op = OP_ADD;
                DIG_OR:  p_op = OP_OR;
                DIG_AND: p_op = OP_AND;
                DIG_SUB: p_op = OP_SUB;
                DIG_XOR: p_op = OP_XOR;
                DIG_CMP: p_op = OP_CMP;
                default: return emit_error(ST_UNSUP);
            endcase
            p_imm = 1;
            need = (opc == OPC_GRP_I8) ? IMM8_BYTES : IMM32_BYTES;
            imm_idx = 0;
            ph = PH_IMM;
            return 0;
        endfunction

        function bit decode_imm(logic [7:0] b);
            logic [63:0] sign;
            imm_acc |= {56'b0, b} << (8 * imm_idx);
            imm_idx++;
            if (need > 0)
                need--;
            if (need != 0)
                return 0;
            if (opc == OPC_GRP_I32 || opc == OPC_GRP_I8)
            begin
                sign = (opc == OPC_GRP_I8) ? 64'h80 : 64'h8000_0000;
                imm_acc = (imm_acc ^ sign) - sign;
            end
            return complete();
        endfunction

        // Called for every accepted code request; queues the record it causes, if any.
        function void note_request(code_req_t r);
            bit done;
            requests_taken++;
            if (r.sn)
            begin
                clear_decode();
                inst_addr = r.a;
                ph = PH_FIRST;
            end
            if (ph == PH_IDLE)
                return;
            if (count < MAX_COUNT)
                count++;
            done = 0;
            case (ph)
                PH_FIRST:
                begin
                    if (r.b >= OPC_REX_LO && r.b <= OPC_REX_HI)
                    begin
                        rex_seen = 1;
                        rex = r.b[3:0];
                        ph = PH_OPCODE;
                    end
                    else
                        done = decode_opcode(r.b);
                end
                PH_OPCODE: done = decode_opcode(r.b);
                PH_MODRM:  done = decode_modrm(r.b);
                default:   done = decode_imm(r.b);
            endcase
            if (!done && r.be)
                void'(emit_error(ST_TRUNC));
        endfunction

        function string rec_text(dec_record_t x);
            return $sformatf("st=%0d op=%0d w=%0d dst=%0d src=%0d imm=%0d val=%h len=%0d addr=%h",
                             x.st, x.op, x.wide, x.dst, x.src, x.has_imm, x.imm_val, x.len,
                             x.addr);
        endfunction

        function void check_record(dec_record_t got);
            dec_record_t want;
            if (expected_records.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected record: %s", $realtime, rec_text(got));
                return;
            end
            want = expected_records.pop_front();
            if (want.st !== got.st || want.op !== got.op || want.wide !== got.wide
                || want.dst !== got.dst || want.src !== got.src
                || want.has_imm !== got.has_imm || want.imm_val !== got.imm_val
                || want.len !== got.len || want.addr !== got.addr)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t record mismatch, expected %s", $realtime, rec_text(want));
                    $display("%0t                  actual   %s", $realtime, rec_text(got));
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        code_valid;
    logic        code_stall;
    logic [7:0]  code_byte;
    logic        start_new;
    logic        buffer_end;
    logic [63:0] start_address;
    logic        record_valid;
    logic        record_stall;
    logic [1:0]  status;
    logic [3:0]  operation;
    logic        wide;
    logic [3:0]  destination;
    logic [3:0]  source;
    logic        has_immediate;
    logic [63:0] immediate_value;
    logic [3:0]  length;
    logic [63:0] decoded_address;

    decoder_scoreboard sb = new();
    int unsigned cycle_count = 0;
    int items_sent = 0;
    bit sender_calm = 0;

    logic [7:0] alu_opcodes [0:14] = '{OPC_ADD_ST, OPC_ADD_LD, OPC_OR_ST, OPC_OR_LD,
                                       OPC_AND_ST, OPC_AND_LD, OPC_SUB_ST, OPC_SUB_LD,
                                       OPC_XOR_ST, OPC_XOR_LD, OPC_CMP_ST, OPC_CMP_LD,
                                       OPC_TEST, OPC_MOV_ST, OPC_MOV_LD};

    x86_scalar_instruction_decoder_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .code_valid      (code_valid),
        .code_stall      (code_stall),
        .code_byte       (code_byte),
        .start_new       (start_new),
        .buffer_end      (buffer_end),
        .start_address   (start_address),
        .record_valid    (record_valid),
        .record_stall    (record_stall),
        .status          (status),
        .operation       (operation),
        .wide            (wide),
        .destination     (destination),
        .source          (source),
        .has_immediate   (has_immediate),
        .immediate_value (immediate_value),
        .length          (length),
        .decoded_address (decoded_address)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_imm_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_modrm();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return {MOD_REG, 6'($urandom)};
    endfunction

    // Mostly ordinary canonical addresses, with a share close to the canonical edges.
    function automatic logic [63:0] pick_address();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return CANON_LOW_MAX - 64'($urandom_range(0, 15));
            2: return 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 15));
            3: return CANON_HI_MIN - 64'($urandom_range(1, 8));
            4: return CANON_HI_MIN + 64'($urandom_range(0, 15));
            5: return {17'h1ffff, 15'($urandom), $urandom};
            default: return {17'h0, 15'($urandom), $urandom};
        endcase
    endfunction

    task automatic send_req(input code_req_t r);
        int gap;
        code_valid <= 1'b1;
        code_byte <= r.b;
        start_new <= r.sn;
        buffer_end <= r.be;
        start_address <= r.a;
        @(posedge clk);
        while (code_stall)
            @(posedge clk);
        sb.note_request(r);
        gap = pick_gap();
        if (gap > 0)
        begin
            code_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Later bytes carry a junk address, which the block must not sample.
    task automatic send_instruction(input logic [7:0] seq[$], input logic [63:0] a,
                                    input int be_at);
        code_req_t r;
        foreach (seq[i])
        begin
            r.b = seq[i];
            r.sn = (i == 0);
            r.be = (i == be_at);
            r.a = (i == 0) ? a : {$urandom, $urandom};
            send_req(r);
        end
    endtask

    task automatic send_random_instruction();
        logic [7:0] seq[$];
        logic [7:0] rex_b;
        logic [7:0] grp;
        bit has_rex;
        int kind;
        int r;
        int be_at;
        int n_imm;
        code_req_t junk;
        seq = {};
        kind = $urandom_range(0, 99);
        rex_b = OPC_REX_LO | 8'($urandom_range(0, 15));
        has_rex = $urandom_range(0, 1);
        if (kind < 8)
        begin
            if ($urandom_range(0, 4) == 0)
                seq = {seq, rex_b};
            seq = {seq, OPC_NOP};
        end
        else if (kind < 30)
        begin
            if (has_rex)
                seq = {seq, rex_b};
            seq = {seq, 8'(OPC_MOVI_LO + 8'($urandom_range(0, 7)))};
            n_imm = (has_rex && rex_b[3]) ? 8 : 4;
            repeat (n_imm) seq = {seq, pick_imm_byte()};
        end
        else if (kind < 65)
        begin
            if (has_rex)
                seq = {seq, rex_b};
            seq = {seq, alu_opcodes[$urandom_range(0, 14)]};
            seq = {seq, pick_modrm()};
        end
        else if (kind < 90)
        begin
            if (has_rex)
                seq = {seq, rex_b};
            grp = $urandom_range(0, 1) ? OPC_GRP_I32 : OPC_GRP_I8;
            seq = {seq, grp};
            seq = {seq, pick_modrm()};
            n_imm = (grp == OPC_GRP_I8) ? 1 : 4;
            repeat (n_imm) seq = {seq, pick_imm_byte()};
        end
        else
        begin
            repeat ($urandom_range(1, 4)) seq = {seq, 8'($urandom)};
        end

        r = $urandom_range(0, 99);
        if (r >= 95 && seq.size() > 1)
        begin
            // Cut short with no end marker: the next start abandons it.
            seq = seq[0:$urandom_range(0, seq.size() - 2)];
            be_at = -1;
        end
        else if (r < 10 && seq.size() > 1)
            be_at = $urandom_range(0, seq.size() - 2);
        else if (r < 40)
            be_at = seq.size() - 1;
        else
            be_at = -1;

        send_instruction(seq, pick_address(), be_at);
        items_sent += seq.size();

        if ($urandom_range(0, 6) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                junk.b = 8'($urandom);
                junk.sn = 1'b0;
                junk.be = $urandom_range(0, 1);
                junk.a = {$urandom, $urandom};
                send_req(junk);
                items_sent++;
            end
        end
    endtask

    // Record side: random stalls, calm stretches and one long hold-off.
    initial
    begin
        dec_record_t got;
        int stall_left;
        int hold;
        int cyc;
        bit pressed;
        bit calm;
        stall_left = 0;
        hold = 0;
        cyc = 0;
        pressed = 0;
        calm = 0;
        record_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && record_valid && !record_stall)
            begin
                got.st = status;
                got.op = operation;
                got.wide = wide;
                got.dst = destination;
                got.src = source;
                got.has_imm = has_immediate;
                got.imm_val = immediate_value;
                got.len = length;
                got.addr = decoded_address;
                sb.check_record(got);
            end
            cyc++;
            if (cyc % 200 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (!pressed && sb.requests_taken >= 500)
            begin
                pressed = 1;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                record_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                record_stall <= 1'b1;
            end
            else if (calm || $urandom_range(0, 99) < 70)
                record_stall <= 1'b0;
            else
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
                record_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [7:0] seq[$];
        code_req_t idle_req;
        int n_instr;
        rst_n <= 1'b0;
        code_valid <= 1'b0;
        code_byte <= '0;
        start_new <= 1'b0;
        buffer_end <= 1'b0;
        start_address <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        seq = {OPC_NOP};
        send_instruction(seq, 64'h0, -1);
        // A REX prefix turns the no-op opcode into an unsupported one.
        seq = {OPC_REX_LO, OPC_NOP};
        send_instruction(seq, 64'h1000, -1);
        seq = {8'h4d, OPC_ADD_ST, 8'hff};
        send_instruction(seq, 64'h2000, -1);
        seq = {OPC_GRP_I8, 8'he8, 8'h80};
        send_instruction(seq, CANON_LOW_MAX - 64'hf, -1);
        seq = {OPC_GRP_I32, 8'hd0};
        send_instruction(seq, 64'h3000, -1);
        seq = {OPC_MOV_ST, 8'h00};
        send_instruction(seq, 64'h3100, -1);
        // Unsupported wins over the end of the buffer on the same byte.
        seq = {8'h0f};
        send_instruction(seq, 64'h3200, 0);
        seq = {OPC_GRP_I32, 8'hf8};
        send_instruction(seq, 64'h3300, 1);
        seq = {OPC_NOP};
        send_instruction(seq, 64'hffff_ffff_ffff_ffff, -1);
        send_instruction(seq, CANON_LOW_MAX, -1);
        idle_req.b = 8'hff;
        idle_req.sn = 1'b0;
        idle_req.be = 1'b1;
        idle_req.a = '1;
        send_req(idle_req);
        // A new start abandons the prefix that is still waiting for its opcode.
        seq = {8'h48};
        send_instruction(seq, 64'h4000, -1);
        seq = {OPC_TEST, 8'hc8};
        send_instruction(seq, CANON_HI_MIN, -1);
        seq = {OPC_XOR_ST, 8'hc0};
        send_instruction(seq, 64'h5000, -1);
        seq = {OPC_OR_LD, 8'hc1};
        send_instruction(seq, 64'h5100, -1);
        seq = {8'h4c, OPC_MOV_LD, 8'hc1};
        send_instruction(seq, 64'h5200, -1);
        seq = {OPC_AND_LD, 8'hd8};
        send_instruction(seq, 64'h5300, -1);
        seq = {OPC_CMP_LD, 8'hc1};
        send_instruction(seq, 64'h5400, -1);

        n_instr = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (n_instr % 100 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            send_random_instruction();
            n_instr++;
        end
        code_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
